[rtl/rlebp_pkg.sv]
// Package with the job descriptor, header characters and sequencer step codes.
package rlebp_pkg;

  // Longest run that one count byte can describe.
  localparam logic [7:0] RUN_CAP = 8'd255;

  // Magic header characters sent at the start of every message.
  localparam logic [7:0] HDR_I = 8'h49;
  localparam logic [7:0] HDR_R = 8'h52;
  localparam logic [7:0] HDR_L = 8'h4C;
  localparam logic [7:0] HDR_E = 8'h45;

  // Step codes of the output sequencer.
  localparam logic [2:0] STEP_HDR_I = 3'd0;
  localparam logic [2:0] STEP_HDR_R = 3'd1;
  localparam logic [2:0] STEP_HDR_L = 3'd2;
  localparam logic [2:0] STEP_HDR_E = 3'd3;
  localparam logic [2:0] STEP_P1_CNT = 3'd4;
  localparam logic [2:0] STEP_P1_VAL = 3'd5;
  localparam logic [2:0] STEP_P2_CNT = 3'd6;
  localparam logic [2:0] STEP_P2_VAL = 3'd7;

  // One (count, value) pair.
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] value;
  } pair_t;

  // Work for the back end caused by one input item.
  typedef struct packed {
    logic  hdr;      // send the four header bytes
    logic  p1_vld;   // send the first pair
    pair_t p1;
    logic  p2_vld;   // send the second pair
    pair_t p2;
    logic  msg_end;  // the final byte of this job ends the message
  } job_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

[rtl/rlebp_if.sv]
// Stream interfaces for raw input bytes and encoded output bytes.
interface rlebp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_last;
  logic       no_data;

  modport source (output valid, output byte_value, output is_last, output no_data,
                  input ready);
  modport sink (input valid, input byte_value, input is_last, input no_data,
                output ready);
endinterface

interface rlebp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       burst_end;
  logic       message_end;

  modport source (output valid, output out_byte, output burst_end, output message_end,
                  input ready);
  modport sink (input valid, input out_byte, input burst_end, input message_end,
                output ready);
endinterface

[rtl/rlebp_front.sv]
// Front end: accepts raw bytes, tracks the pending run and builds output jobs.
module rlebp_front (
  input  logic                clk,
  input  logic                rst_n,
  rlebp_in_if.sink            in_ch,
  output rlebp_pkg::job_push_t push,
  input  logic                push_ready
);

  logic       in_msg_r, in_msg_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic [7:0] run_r, run_nxt;
  logic       take;
  logic [7:0] pend_cnt;
  logic [7:0] pend_val;
  rlebp_pkg::job_t job;

  // An item is taken whenever the queue has room; items without work skip it.
  assign in_ch.ready = push_ready;
  assign take        = in_ch.valid && push_ready;

  // Classify the item and work out the next run state.
  always_comb begin
    job        = '0;
    in_msg_nxt = in_msg_r;
    cur_nxt    = cur_r;
    run_nxt    = run_r;
    pend_cnt   = run_r;
    pend_val   = cur_r;
    if (in_ch.no_data) begin
      if (in_ch.is_last) begin
        if (!in_msg_r) begin
          job.hdr = 1'b1;
        end else begin
          job.p1_vld   = 1'b1;
          job.p1.count = run_r;
          job.p1.value = cur_r;
        end
        job.msg_end = 1'b1;
        in_msg_nxt  = 1'b0;
        cur_nxt     = '0;
        run_nxt     = '0;
      end
    end else begin
      if (!in_msg_r) begin
        job.hdr  = 1'b1;
        pend_cnt = 8'd1;
        pend_val = in_ch.byte_value;
      end else if (in_ch.byte_value == cur_r && run_r != rlebp_pkg::RUN_CAP) begin
        pend_cnt = run_r + 8'd1;
        pend_val = cur_r;
      end else begin
        job.p1_vld   = 1'b1;
        job.p1.count = run_r;
        job.p1.value = cur_r;
        pend_cnt     = 8'd1;
        pend_val     = in_ch.byte_value;
      end
      in_msg_nxt = 1'b1;
      cur_nxt    = pend_val;
      run_nxt    = pend_cnt;
      // Message end flushes the pending run into the next free pair slot.
      if (in_ch.is_last) begin
        if (job.p1_vld) begin
          job.p2_vld   = 1'b1;
          job.p2.count = pend_cnt;
          job.p2.value = pend_val;
        end else begin
          job.p1_vld   = 1'b1;
          job.p1.count = pend_cnt;
          job.p1.value = pend_val;
        end
        job.msg_end = 1'b1;
        in_msg_nxt  = 1'b0;
        cur_nxt     = '0;
        run_nxt     = '0;
      end
    end
  end

  assign push.valid = take && (job.hdr || job.p1_vld);
  assign push.job   = job;

  // Run state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      cur_r    <= '0;
      run_r    <= '0;
    end else if (take) begin
      in_msg_r <= in_msg_nxt;
      cur_r    <= cur_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

[rtl/rlebp_queue.sv]
// Two-entry job queue between the front end and the back end.
module rlebp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlebp_pkg::job_push_t push,
  output logic                 push_ready,
  output logic                 pop_valid,
  output rlebp_pkg::job_t      pop_job,
  input  logic                 pop
);

  rlebp_pkg::job_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[rtl/rlebp_back.sv]
// Back end: walks each job byte by byte into the registered output stage.
module rlebp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  rlebp_pkg::job_t job_in,
  output logic            job_pop,
  rlebp_out_if.source     out_ch
);

  logic            busy_r, busy_nxt;
  rlebp_pkg::job_t job_r;
  logic [2:0]      step_r, step_nxt;
  logic            out_valid_r;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            burst_end_r, burst_end_nxt;
  logic            msg_end_r, msg_end_nxt;

  rlebp_pkg::job_t cur_job;
  logic [2:0]      cur_step;
  logic [2:0]      start_step;
  logic            have;
  logic            load;
  logic            final_step;

  // The output register takes a byte when empty or being drained.
  assign load = !out_valid_r || out_ch.ready;

  // First step of a job fresh from the queue.
  assign start_step = job_in.hdr ? rlebp_pkg::STEP_HDR_I : rlebp_pkg::STEP_P1_CNT;

  assign cur_job  = busy_r ? job_r : job_in;
  assign cur_step = busy_r ? step_r : start_step;
  assign have     = busy_r || job_valid;
  assign job_pop  = load && !busy_r && job_valid;

  // Select the byte for the current step and find the next step.
  always_comb begin
    out_byte_nxt = '0;
    step_nxt     = cur_step + 3'd1;
    final_step   = 1'b0;
    case (cur_step)
      rlebp_pkg::STEP_HDR_I:  out_byte_nxt = rlebp_pkg::HDR_I;
      rlebp_pkg::STEP_HDR_R:  out_byte_nxt = rlebp_pkg::HDR_R;
      rlebp_pkg::STEP_HDR_L:  out_byte_nxt = rlebp_pkg::HDR_L;
      rlebp_pkg::STEP_HDR_E: begin
        out_byte_nxt = rlebp_pkg::HDR_E;
        final_step   = !cur_job.p1_vld;
      end
      rlebp_pkg::STEP_P1_CNT: out_byte_nxt = cur_job.p1.count;
      rlebp_pkg::STEP_P1_VAL: begin
        out_byte_nxt = cur_job.p1.value;
        final_step   = !cur_job.p2_vld;
      end
      rlebp_pkg::STEP_P2_CNT: out_byte_nxt = cur_job.p2.count;
      rlebp_pkg::STEP_P2_VAL: begin
        out_byte_nxt = cur_job.p2.value;
        final_step   = 1'b1;
      end
      default: out_byte_nxt = '0;
    endcase
    burst_end_nxt = final_step;
    msg_end_nxt   = final_step && cur_job.msg_end;
    busy_nxt      = !final_step;
  end

  // Sequencer control and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= have;
      if (have) begin
        busy_r <= busy_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load && have) begin
      job_r       <= cur_job;
      step_r      <= step_nxt;
      out_byte_r  <= out_byte_nxt;
      burst_end_r <= burst_end_nxt;
      msg_end_r   <= msg_end_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.burst_end   = burst_end_r;
  assign out_ch.message_end = msg_end_r;

endmodule

[rtl/rle_byte_pair_encoder_top.sv]
// Run-length encoder top level producing (count, value) byte pairs.
//
// in_ch carries one raw byte per transfer with is_last and no_data flags;
// out_ch carries one encoded byte per transfer with burst_end and
// message_end. Both use valid/ready; a transfer happens when both are high.
// Each message opens with the header bytes I, R, L, E, followed by a
// run count and value byte for every run of up to 255 equal bytes.
// The front end updates the run state in the cycle of the input transfer
// and writes a job into a two-entry queue; the back end emits one byte per
// cycle from its output register while a job waits and the receiver is ready.
// The first result byte of an item passes through the queue and then the output register.
// Throughput is set by the one-byte output port: an item that closes a run
// yields two bytes, a last byte that closes two runs four, one that extends
// a run none, a message start with its header four to six, so on a stream
// of distinct bytes the output port, not the input, is the limit. Input is taken every
// cycle while the queue has room.
// Synchronous active-low reset returns to the idle state between messages
// and empties the queue and output register. When the receiver stalls,
// the output byte holds, the queue fills and then in_ch.ready drops.
module rle_byte_pair_encoder_top (
  input logic          clk,
  input logic          rst_n,
  rlebp_in_if.sink     in_ch,
  rlebp_out_if.source  out_ch
);

  rlebp_pkg::job_push_t push;
  logic                 push_ready;
  logic                 job_valid;
  rlebp_pkg::job_t      job;
  logic                 job_pop;

  rlebp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  rlebp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (job_valid),
    .pop_job    (job),
    .pop        (job_pop)
  );

  rlebp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_in    (job),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

endmodule

[dv/rle_byte_pair_encoder_top_tb.sv]
// Self-checking testbench for the run-length byte pair encoder.
module rle_byte_pair_encoder_top_tb;

  // One encoded output byte together with its framing flags.
  typedef struct packed {
    logic [7:0] value;
    logic       burst_end;
    logic       message_end;
  } coded_byte_t;

  // A directed stimulus row. When fixed is set, the expected bytes are typed in.
  // The last typed byte carries burst_end and message_end.
  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    logic        no_data;
    logic [8:0]  reps;
    logic        fixed;
    logic [2:0]  n_fixed;
    logic [47:0] fixed_bytes;
  } stim_row_t;

  localparam logic [7:0] HDR_CHARS [4] = '{rlebp_pkg::HDR_I, rlebp_pkg::HDR_R,
                                           rlebp_pkg::HDR_L, rlebp_pkg::HDR_E};
  localparam logic [31:0] IRLE = {rlebp_pkg::HDR_I, rlebp_pkg::HDR_R,
                                  rlebp_pkg::HDR_L, rlebp_pkg::HDR_E};
  localparam int STALL_PCT = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 110;
  localparam int NUM_ROWS = 22;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Empty message right after reset: header only.
    '{8'h00, 1'b1, 1'b1, 9'd1,   1'b1, 3'd4, {IRLE, 16'h0000}},
    // Bubble while idle: nothing comes out.
    '{8'hA5, 1'b0, 1'b1, 9'd1,   1'b1, 3'd0, 48'h0},
    // One-byte messages at both extremes of the byte range.
    '{8'h00, 1'b1, 1'b0, 9'd1,   1'b1, 3'd6, {IRLE, 8'h01, 8'h00}},
    '{8'hFF, 1'b1, 1'b0, 9'd1,   1'b1, 3'd6, {IRLE, 8'h01, 8'hFF}},
    // Empty message whose byte field must be ignored.
    '{8'h5A, 1'b1, 1'b1, 9'd1,   1'b1, 3'd4, {IRLE, 16'h0000}},
    // Short run, bubble inside the message, value change, run closed by last.
    '{8'h11, 1'b0, 1'b0, 9'd2,   1'b0, 3'd0, 48'h0},
    '{8'hFF, 1'b0, 1'b1, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'h22, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'h22, 1'b1, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    // Message closed by an empty end.
    '{8'h33, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'h00, 1'b1, 1'b1, 9'd1,   1'b0, 3'd0, 48'h0},
    // Last byte differs from the run: two pairs from one item.
    '{8'h44, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'h55, 1'b1, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    // Run reaches the cap, then one more equal byte splits it.
    '{8'h77, 1'b0, 1'b0, 9'd255, 1'b0, 3'd0, 48'h0},
    '{8'h77, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'h78, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    // Equal last byte at the cap: capped pair plus a pair of one.
    '{8'h66, 1'b0, 1'b0, 9'd255, 1'b0, 3'd0, 48'h0},
    '{8'h66, 1'b1, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    // Full run flushed by an empty end.
    '{8'h99, 1'b0, 1'b0, 9'd255, 1'b0, 3'd0, 48'h0},
    '{8'h99, 1'b1, 1'b1, 9'd1,   1'b0, 3'd0, 48'h0},
    // Extreme values inside one message.
    '{8'h00, 1'b0, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0},
    '{8'hFF, 1'b1, 1'b0, 9'd1,   1'b0, 3'd0, 48'h0}
  };

  logic clk;
  logic rst_n;

  rlebp_in_if  in_if ();
  rlebp_out_if out_if ();

  rle_byte_pair_encoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Encoder state as the testbench sees it.
  logic       msg_open;
  logic [7:0] run_value;
  logic [7:0] run_count;

  coded_byte_t item_bytes [$];
  coded_byte_t pending_bytes [$];

  // Typed expectation that travels with the item on the input channel.
  logic        cur_fixed;
  logic [2:0]  cur_n_fixed;
  logic [47:0] cur_fixed_bytes;

  logic steady;
  int   mismatches;
  int   data_items;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void push_byte(input logic [7:0] value, input logic msg_end);
    item_bytes.push_back('{value, 1'b0, msg_end});
  endfunction

  function automatic void emit_header(input logic msg_end);
    for (int i = 0; i < 4; i++) begin
      push_byte(HDR_CHARS[i], msg_end && (i == 3));
    end
  endfunction

  function automatic void emit_pair(input logic msg_end);
    push_byte(run_count, 1'b0);
    push_byte(run_value, msg_end);
  endfunction

  // Works out the bytes that one accepted input item produces.
  function automatic void rle_encode_item(input logic [7:0] value, input logic last,
                                          input logic no_data);
    item_bytes.delete();
    if (no_data) begin
      if (!last) begin
        return;
      end
      if (!msg_open) begin
        emit_header(1'b1);
      end else begin
        emit_pair(1'b1);
      end
      msg_open  = 1'b0;
      run_value = 8'h00;
      run_count = 8'h00;
    end else begin
      if (!msg_open) begin
        emit_header(1'b0);
        msg_open  = 1'b1;
        run_value = value;
        run_count = 8'd1;
      end else if (value == run_value && run_count != rlebp_pkg::RUN_CAP) begin
        run_count = run_count + 8'd1;
      end else begin
        emit_pair(1'b0);
        run_value = value;
        run_count = 8'd1;
      end
      if (last) begin
        emit_pair(1'b1);
        msg_open  = 1'b0;
        run_value = 8'h00;
        run_count = 8'h00;
      end
    end
    if (item_bytes.size() > 0) begin
      item_bytes[item_bytes.size() - 1].burst_end = 1'b1;
    end
  endfunction

  // Predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        rle_encode_item(in_if.byte_value, in_if.is_last, in_if.no_data);
        if (cur_fixed) begin
          item_bytes.delete();
          for (int i = 0; i < cur_n_fixed; i++) begin
            item_bytes.push_back('{cur_fixed_bytes[47 - 8 * i -: 8],
                                   i == cur_n_fixed - 1, i == cur_n_fixed - 1});
          end
        end
        foreach (item_bytes[k]) begin
          pending_bytes.push_back(item_bytes[k]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_if.out_byte));
        end else begin
          want = pending_bytes.pop_front();
          if (out_if.out_byte !== want.value) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte,
                                      want.value));
          end
          if (out_if.burst_end !== want.burst_end) begin
            report_mismatch($sformatf("burst_end %b, want %b on byte %02h",
                                      out_if.burst_end, want.burst_end, want.value));
          end
          if (out_if.message_end !== want.message_end) begin
            report_mismatch($sformatf("message_end %b, want %b on byte %02h",
                                      out_if.message_end, want.message_end, want.value));
          end
        end
      end
    end
  end

  // Stops a hung run: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls at random, except inside the steady window.
  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // Offers one item, with a random gap first, and returns after its transfer.
  task automatic send_item(input logic [7:0] value, input logic last, input logic no_data,
                           input logic fixed = 1'b0, input logic [2:0] n_fixed = 3'd0,
                           input logic [47:0] fixed_bytes = 48'h0);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_if.valid      <= 1'b0;
      in_if.byte_value <= 8'($urandom);
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.byte_value <= value;
    in_if.is_last    <= last;
    in_if.no_data    <= no_data;
    cur_fixed        <= fixed;
    cur_n_fixed      <= n_fixed;
    cur_fixed_bytes  <= fixed_bytes;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (!no_data || last) begin
      data_items++;
    end
    @(negedge clk);
  endtask

  initial begin
    stim_row_t   row;
    int          base_items;
    int          kind;
    int          msg_len;
    int          spread;
    logic        end_empty;
    logic [7:0]  base_value;
    logic [7:0]  value;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.byte_value <= 8'h00;
    in_if.is_last    <= 1'b0;
    in_if.no_data    <= 1'b0;
    cur_fixed        <= 1'b0;
    cur_n_fixed      <= 3'd0;
    cur_fixed_bytes  <= 48'h0;
    steady           <= 1'b0;
    msg_open    = 1'b0;
    run_value   = 8'h00;
    run_count   = 8'h00;
    mismatches  = 0;
    data_items  = 0;
    idle_cycles = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      for (int k = 0; k < row.reps; k++) begin
        send_item(row.value, row.last && (k == row.reps - 1), row.no_data, row.fixed,
                  row.n_fixed, row.fixed_bytes);
      end
    end

    // Random part: mostly well-formed messages, with noise in between.
    base_items = data_items;
    while (data_items - base_items < RANDOM_ITEMS) begin
      steady <= (data_items - base_items >= 40) && (data_items - base_items < 70);
      kind = $urandom_range(99);
      if (kind < 72) begin
        // Message of random length; a narrow value spread makes runs likely.
        msg_len    = $urandom_range(1, 8);
        spread     = ($urandom_range(1) == 1) ? 2 : 255;
        base_value = 8'($urandom);
        end_empty  = ($urandom_range(4) == 0);
        for (int k = 0; k < msg_len; k++) begin
          if ($urandom_range(9) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
          end
          value = base_value + 8'($urandom_range(spread));
          send_item(value, !end_empty && (k == msg_len - 1), 1'b0);
        end
        if (end_empty) begin
          send_item(8'($urandom), 1'b1, 1'b1);
        end
      end else if (kind < 82) begin
        send_item(8'($urandom), 1'b1, 1'b1);
      end else if (kind < 97) begin
        send_item(8'($urandom), 1'b0, 1'b1);
      end else begin
        // Long run around the cap.
        msg_len = $urandom_range(250, 260);
        value   = 8'($urandom);
        for (int k = 0; k < msg_len; k++) begin
          send_item(value, k == msg_len - 1, 1'b0);
        end
      end
    end
    steady      <= 1'b0;
    in_if.valid <= 1'b0;

    // Drain and let any stray output show up.
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rlebp_pkg.sv
rtl/rlebp_if.sv
rtl/rlebp_front.sv
rtl/rlebp_queue.sv
rtl/rlebp_back.sv
rtl/rle_byte_pair_encoder_top.sv
dv/rle_byte_pair_encoder_top_tb.sv
